FILE: rtl/core/pan_pkg.sv
// ----------------------------------------------------------------------------
// pan_pkg - shared types and constants of the periodic alarm block
// Field widths, entry kinds, commands, FSM states and divider transactions.
// ----------------------------------------------------------------------------
package pan_pkg;

  localparam int ENTRIES_DEF = 8;

  localparam int CMD_W     = 1;
  localparam int IDX_W     = 3;
  localparam int KIND_W    = 2;
  localparam int HOURS_W   = 8;
  localparam int MINS_W    = 6;
  localparam int EPOCH_W   = 32;
  localparam int MINUTE_W  = 27;
  localparam int MULT_W    = 8;

  // slots addressable through entry_index
  localparam int MAX_SLOTS = 2 ** IDX_W;

  localparam int SECS_PER_MIN = 60;
  localparam int GUARD_SECS   = 2;

  // divider widths: epoch + 2 needs one extra bit, periods are 8 x 8 bits
  localparam int DIVIDEND_W = EPOCH_W + 1;
  localparam int DIVISOR_W  = HOURS_W + MULT_W;
  localparam int PERIOD_W   = HOURS_W + MULT_W;
  localparam int HOUR_W     = 21;                 // now / 60
  localparam int P60_W      = PERIOD_W + 6;       // period * 60
  localparam int V_W        = MINUTE_W + 1;       // candidate before clamp

  localparam logic [MULT_W-1:0]   MULT_RESET  = 8'd1;
  localparam logic [MINUTE_W-1:0] NONE_MINUTE = 27'd71582788;

  localparam logic [KIND_W-1:0] KIND_MINUTES = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HOURS   = 2'd2;

  localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NOW_RUN,
    ST_HR_GO,
    ST_HR_RUN,
    ST_RD,
    ST_PER,
    ST_MOD_GO,
    ST_MOD_RUN,
    ST_SCALE,
    ST_OFFS,
    ST_ADJ,
    ST_MINSEL,
    ST_DONE
  } pan_state_t;

  typedef struct packed {
    logic [HOURS_W-1:0] hours;
    logic [MINS_W-1:0]  minutes;
    logic [KIND_W-1:0]  kind;
  } pan_entry_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } pan_div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVISOR_W-1:0]  remainder;
  } pan_div_rsp_t;

endpackage

FILE: rtl/core/pan_if.sv
// ----------------------------------------------------------------------------
// pan_if - channel interfaces of the periodic alarm block
// Command input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface pan_in_if;
  import pan_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [IDX_W-1:0]     entry_index;
  logic [KIND_W-1:0]    entry_kind;
  logic [HOURS_W-1:0]   entry_hours;
  logic [MINS_W-1:0]    entry_minutes;
  logic [EPOCH_W-1:0]   epoch_seconds;

  modport source (output valid, command, entry_index, entry_kind, entry_hours,
                  entry_minutes, epoch_seconds, input ready);
  modport sink   (input valid, command, entry_index, entry_kind, entry_hours,
                  entry_minutes, epoch_seconds, output ready);
endinterface

interface pan_out_if;
  import pan_pkg::*;

  logic                valid;
  logic                ready;
  logic [MINUTE_W-1:0] next_minute;
  logic                alarm_found;

  modport source (output valid, next_minute, alarm_found, input ready);
  modport sink   (input valid, next_minute, alarm_found, output ready);
endinterface

interface pan_cfg_if;
  import pan_pkg::*;

  logic              valid;
  logic              ready;
  logic [MULT_W-1:0] period_multiplier;

  modport source (output valid, period_multiplier, input ready);
  modport sink   (input valid, period_multiplier, output ready);
endinterface

FILE: rtl/core/pan_div.sv
// ----------------------------------------------------------------------------
// pan_div - bit-serial restoring divider
// One quotient bit per cycle; quotient and remainder hold until next start.
// ----------------------------------------------------------------------------
module pan_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pan_pkg::pan_div_req_t req,
  output pan_pkg::pan_div_rsp_t rsp
);
  import pan_pkg::*;

  localparam int              CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVIDEND_W - 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] dq_r, dq_nxt;     // dividend bits out at top, quotient in at bottom
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;

  logic [DIVISOR_W:0] trial;
  logic [DIVISOR_W:0] diff;
  logic               geq;

  assign trial = {rem_r, dq_r[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign geq   = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dq_nxt   = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      dq_nxt  = {dq_r[DIVIDEND_W-2:0], geq};
      // trial < 2 * divisor, so the difference fits the remainder width
      rem_nxt = geq ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = dq_r;
  assign rsp.remainder = rem_r;

endmodule

FILE: rtl/core/pan_table.sv
// ----------------------------------------------------------------------------
// pan_table - action table
// Slot registers cleared to disabled at reset, one write port, registered read.
// ----------------------------------------------------------------------------
module pan_table #(
  parameter  int DEPTH = pan_pkg::MAX_SLOTS,
  localparam int RD_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [pan_pkg::IDX_W-1:0] wr_idx,
  input  pan_pkg::pan_entry_t      wr_data,
  input  logic [RD_W-1:0]          rd_idx,
  output pan_pkg::pan_entry_t      rd_data
);
  import pan_pkg::*;

  pan_entry_t slot_r [DEPTH];
  pan_entry_t rd_data_r;
  logic       wr_ok;

  // writes past the stored depth are dropped
  assign wr_ok = wr_en && (32'(wr_idx) < DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        slot_r[i] <= '0;
      end
    end else if (wr_ok) begin
      slot_r[wr_idx[RD_W-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= slot_r[rd_idx];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/periodic_alarm_next_minute.sv
// ----------------------------------------------------------------------------
// periodic_alarm_next_minute - next alarm minute over a periodic action table
// A write command stores a slot when it is taken. A query runs all of its
// divisions on the one shared bit-serial divider: (epoch + 2) / 60,
// now / 60, and one remainder per enabled slot. The input is held off while
// a query runs; a write can be taken while a finished result waits in the
// output register. Only the first min(ENTRIES, 8) slots are stored, the rest
// read as disabled.
// ----------------------------------------------------------------------------
module periodic_alarm_next_minute #(
  parameter int ENTRIES = pan_pkg::ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  pan_in_if.sink        in_ch,
  pan_out_if.source     out_ch,
  pan_cfg_if.sink       cfg_ch
);
  import pan_pkg::*;

  localparam int TBL_DEPTH = (ENTRIES < MAX_SLOTS) ? ENTRIES : MAX_SLOTS;
  localparam int RD_W      = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam logic [RD_W-1:0] LAST_IDX = RD_W'(TBL_DEPTH - 1);

  pan_state_t state_r, state_nxt;

  logic [MULT_W-1:0]   mult_r, mult_nxt;
  logic [MINUTE_W-1:0] now_r, now_nxt;
  logic [HOUR_W-1:0]   hr_r, hr_nxt;
  logic [RD_W-1:0]     idx_r, idx_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [MINS_W-1:0]   mins_r, mins_nxt;
  logic [PERIOD_W-1:0] p_r, p_nxt;
  logic [MINUTE_W-1:0] base_r, base_nxt;
  logic [P60_W-1:0]    p60_r, p60_nxt;
  logic [V_W-1:0]      v_r, v_nxt;
  logic [MINUTE_W-1:0] min_r, min_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [MINUTE_W-1:0] out_minute_r, out_minute_nxt;
  logic                out_found_r, out_found_nxt;

  pan_div_req_t div_req;
  pan_div_rsp_t div_rsp;
  pan_entry_t   ent;
  pan_entry_t   wr_entry;

  logic                in_acc, q_acc, w_acc;
  logic                en, last, out_free, step, out_load;
  logic [HOURS_W-1:0]  prod_a;
  logic [HOUR_W-1:0]   hq;
  logic [MINUTE_W-1:0] cand;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign q_acc    = in_acc && (in_ch.command == CMD_QUERY);
  assign w_acc    = in_acc && (in_ch.command == CMD_WRITE);
  assign en       = (p_r != '0) && ((kind_r == KIND_MINUTES) || (kind_r == KIND_HOURS));
  assign last     = (idx_r == LAST_IDX);
  assign out_free = !out_valid_r || out_ch.ready;

  assign wr_entry = '{hours: in_ch.entry_hours, minutes: in_ch.entry_minutes,
                      kind: in_ch.entry_kind};

  pan_table #(.DEPTH(TBL_DEPTH)) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (w_acc),
    .wr_idx  (in_ch.entry_index),
    .wr_data (wr_entry),
    .rd_idx  (idx_r),
    .rd_data (ent)
  );

  pan_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (q_acc) state_nxt = ST_NOW_RUN;
      ST_NOW_RUN: if (div_rsp.done) state_nxt = ST_HR_GO;
      ST_HR_GO:   state_nxt = ST_HR_RUN;
      ST_HR_RUN:  if (div_rsp.done) state_nxt = ST_RD;
      ST_RD:      state_nxt = ST_PER;
      ST_PER:     state_nxt = ST_MOD_GO;
      ST_MOD_GO: begin
        if (en)        state_nxt = ST_MOD_RUN;
        else if (last) state_nxt = ST_DONE;
        else           state_nxt = ST_RD;
      end
      ST_MOD_RUN: if (div_rsp.done) state_nxt = ST_SCALE;
      ST_SCALE:   state_nxt = ST_OFFS;
      ST_OFFS:    state_nxt = ST_ADJ;
      ST_ADJ:     state_nxt = ST_MINSEL;
      ST_MINSEL:  state_nxt = last ? ST_DONE : ST_RD;
      ST_DONE:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready      = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DIVIDEND_W'(kind_r == KIND_MINUTES ? HOUR_W'(0) : hr_r);
    div_req.divisor  = p_r;
    step             = 1'b0;
    out_load         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready      = 1'b1;
        div_req.start    = q_acc;
        div_req.dividend = DIVIDEND_W'(in_ch.epoch_seconds) + DIVIDEND_W'(GUARD_SECS);
        div_req.divisor  = DIVISOR_W'(SECS_PER_MIN);
      end
      ST_HR_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIVIDEND_W'(now_r);
        div_req.divisor  = DIVISOR_W'(SECS_PER_MIN);
      end
      ST_MOD_GO: begin
        div_req.start = en;
        if (kind_r == KIND_MINUTES) begin
          div_req.dividend = DIVIDEND_W'(now_r);
        end
        step = !en;
      end
      ST_MINSEL: step = 1'b1;
      ST_DONE:   out_load = out_free;
      default: ;
    endcase
  end

  assign prod_a = (ent.kind == KIND_HOURS) ? ent.hours : HOURS_W'(ent.minutes);
  // remainder never exceeds the hour count it was taken from
  assign hq     = hr_r - HOUR_W'(div_rsp.remainder);
  assign cand   = (v_r >= V_W'(NONE_MINUTE)) ? NONE_MINUTE : v_r[MINUTE_W-1:0];

  // datapath
  always_comb begin
    mult_nxt       = mult_r;
    now_nxt        = now_r;
    hr_nxt         = hr_r;
    idx_nxt        = idx_r;
    kind_nxt       = kind_r;
    mins_nxt       = mins_r;
    p_nxt          = p_r;
    base_nxt       = base_r;
    p60_nxt        = p60_r;
    v_nxt          = v_r;
    min_nxt        = min_r;
    out_valid_nxt  = out_valid_r;
    out_minute_nxt = out_minute_r;
    out_found_nxt  = out_found_r;

    if (cfg_ch.valid && cfg_ch.ready) begin
      mult_nxt = cfg_ch.period_multiplier;
    end

    if (state_r == ST_NOW_RUN && div_rsp.done) begin
      now_nxt = div_rsp.quotient[MINUTE_W-1:0];
    end
    if (state_r == ST_HR_RUN && div_rsp.done) begin
      hr_nxt  = div_rsp.quotient[HOUR_W-1:0];
      idx_nxt = '0;
      min_nxt = NONE_MINUTE;
    end
    if (state_r == ST_PER) begin
      kind_nxt = ent.kind;
      mins_nxt = ent.minutes;
      p_nxt    = PERIOD_W'(prod_a) * PERIOD_W'(mult_r);
    end
    if (state_r == ST_SCALE) begin
      if (kind_r == KIND_MINUTES) begin
        // (now / p + 1) * p  ==  now - now % p + p
        v_nxt = V_W'(now_r) - V_W'(div_rsp.remainder) + V_W'(p_r);
      end else begin
        base_nxt = MINUTE_W'(hq) * MINUTE_W'(SECS_PER_MIN);
        p60_nxt  = P60_W'(p_r) * P60_W'(SECS_PER_MIN);
      end
    end
    if (state_r == ST_OFFS && kind_r == KIND_HOURS) begin
      v_nxt = V_W'(base_r) + V_W'(mins_r);
    end
    if (state_r == ST_ADJ && kind_r == KIND_HOURS && v_r <= V_W'(now_r)) begin
      v_nxt = v_r + V_W'(p60_r);
    end
    if (state_r == ST_MINSEL && cand < min_r) begin
      min_nxt = cand;
    end
    if (step && !last) begin
      idx_nxt = idx_r + 1'b1;
    end

    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_minute_nxt = min_r;
      out_found_nxt  = (min_r != NONE_MINUTE);
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mult_r      <= MULT_RESET;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mult_r      <= mult_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r        <= now_nxt;
    hr_r         <= hr_nxt;
    kind_r       <= kind_nxt;
    mins_r       <= mins_nxt;
    p_r          <= p_nxt;
    base_r       <= base_nxt;
    p60_r        <= p60_nxt;
    v_r          <= v_nxt;
    min_r        <= min_nxt;
    out_minute_r <= out_minute_nxt;
    out_found_r  <= out_found_nxt;
  end

  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.next_minute = out_minute_r;
  assign out_ch.alarm_found = out_found_r;

endmodule

FILE: rtl/core/pan_checker.sv
// ----------------------------------------------------------------------------
// pan_checker - port-level assertions for periodic_alarm_next_minute
// Result consistency and query timing, bound to the top level.
// ----------------------------------------------------------------------------
module pan_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [pan_pkg::CMD_W-1:0]     in_command,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pan_pkg::MINUTE_W-1:0]  next_minute,
  input logic                          alarm_found
);
  import pan_pkg::*;

  logic q_acc;
  assign q_acc = in_valid && in_ready && (in_command == CMD_QUERY);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(next_minute) && $stable(alarm_found))
    else $error("result changed while stalled");

  a_found_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (alarm_found == (next_minute != NONE_MINUTE)))
    else $error("alarm_found disagrees with next_minute");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (next_minute <= NONE_MINUTE))
    else $error("next_minute above no-alarm value");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_acc |=> !in_ready)
    else $error("input taken while a query runs");

  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    q_acc |=> !$rose(out_valid))
    else $error("result appeared right after query transaction");

endmodule

bind periodic_alarm_next_minute pan_checker u_pan_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_command  (in_ch.command),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .next_minute (out_ch.next_minute),
  .alarm_found (out_ch.alarm_found)
);

FILE: tb/sv/periodic_alarm_next_minute_tb.sv
// ----------------------------------------------------------------------------
// periodic_alarm_next_minute_tb - self-checking bench for the next alarm block
// A short directed table of slot writes, queries and multiplier changes
// comes first. It is followed by phases of random writes and queries, each
// phase under its own multiplier. Every query result is checked against a
// local model of the action table or a fixed expected value. Both channels idle at random. There is
// one long receiver hold-off and one sender pause to drain.
// ----------------------------------------------------------------------------
module periodic_alarm_next_minute_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pan_pkg::*;

  localparam int ENTRIES = ENTRIES_DEF;
  localparam logic [KIND_W-1:0]  KIND_OFF   = 2'd0;
  localparam logic [KIND_W-1:0]  KIND_SPARE = 2'd3;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX  = 32'd4294967293;

  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 60;
  localparam int HOLD_CYCLES    = 1500;
  localparam int SETTLE_CYCLES  = 16;
  localparam int DRAIN_CYCLES   = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int REPORT_MAX     = 10;

  typedef enum int {ROW_ITEM, ROW_CFG} row_op_t;

  typedef struct packed {
    logic [MINUTE_W-1:0] minute;
    logic                found;
  } alarm_t;

  typedef struct {
    row_op_t             op;
    logic [CMD_W-1:0]    cmd;
    logic [IDX_W-1:0]    idx;
    pan_entry_t          entry;
    logic [EPOCH_W-1:0]  epoch;
    logic [MULT_W-1:0]   mult;
    bit                  known;
    alarm_t              want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  pan_in_if  in_bus ();
  pan_out_if out_bus ();
  pan_cfg_if cfg_bus ();

  periodic_alarm_next_minute #(
    .ENTRIES (ENTRIES)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // model state
  pan_entry_t        slot_model [ENTRIES];
  logic [MULT_W-1:0] mult_model;
  alarm_t            alarm_q [$];
  stim_row_t         plan [$];

  int mismatches = 0;
  int n_queries  = 0;
  int n_writes   = 0;
  int n_results  = 0;
  int n_cfg      = 0;
  int n_holds    = 0;
  bit hold_req   = 1'b0;
  bit quiet      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // earliest alarm minute over the modeled table for one query epoch
  function automatic alarm_t next_alarm(logic [EPOCH_W-1:0] epoch);
    longint unsigned now;
    longint unsigned best;
    longint unsigned cand;
    longint unsigned per;
    longint unsigned q;
    alarm_t          a;
    now  = (64'(epoch) + 64'(GUARD_SECS)) / 64'(SECS_PER_MIN);
    best = 64'(NONE_MINUTE);
    for (int i = 0; i < ENTRIES; i++) begin
      cand = 64'(NONE_MINUTE);
      if (slot_model[i].kind == KIND_MINUTES) begin
        per = 64'(slot_model[i].minutes) * 64'(mult_model);
        if (per != 0) cand = (now / per + 1) * per;
      end else if (slot_model[i].kind == KIND_HOURS) begin
        per = 64'(slot_model[i].hours) * 64'(mult_model);
        if (per != 0) begin
          q    = (now / 64'(SECS_PER_MIN)) / per;
          cand = q * per * 64'(SECS_PER_MIN) + 64'(slot_model[i].minutes);
          // offset already passed in this period: take the next one
          if (cand <= now)
            cand = (q + 1) * per * 64'(SECS_PER_MIN) + 64'(slot_model[i].minutes);
        end
      end
      if (cand >= 64'(NONE_MINUTE)) cand = 64'(NONE_MINUTE);
      if (cand < best) best = cand;
    end
    a.minute = best[MINUTE_W-1:0];
    a.found  = (best < 64'(NONE_MINUTE));
    return a;
  endfunction

  task automatic note_error(string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("ERROR: %s", msg);
  endtask

  task automatic add_write(int idx, logic [KIND_W-1:0] kind, int hours, int mins);
    stim_row_t r;
    r.op      = ROW_ITEM;
    r.cmd     = CMD_WRITE;
    r.idx     = IDX_W'(idx);
    r.entry   = '{hours: HOURS_W'(hours), minutes: MINS_W'(mins), kind: kind};
    r.epoch   = '0;
    r.mult    = '0;
    r.known   = 1'b0;
    r.want    = '0;
    plan.push_back(r);
  endtask

  task automatic add_query(logic [EPOCH_W-1:0] epoch, bit known = 1'b0,
                           logic [MINUTE_W-1:0] minute = '0, logic found = 1'b0);
    stim_row_t r;
    r.op          = ROW_ITEM;
    r.cmd         = CMD_QUERY;
    r.idx         = '0;
    r.entry       = '0;
    r.epoch       = epoch;
    r.mult        = '0;
    r.known       = known;
    r.want.minute = minute;
    r.want.found  = found;
    plan.push_back(r);
  endtask

  task automatic add_cfg(logic [MULT_W-1:0] m);
    stim_row_t r;
    r.op    = ROW_CFG;
    r.cmd   = CMD_WRITE;
    r.idx   = '0;
    r.entry = '0;
    r.epoch = '0;
    r.mult  = m;
    r.known = 1'b0;
    r.want  = '0;
    plan.push_back(r);
  endtask

  // called at a rising edge; returns at the edge of the transaction
  task automatic send_item(stim_row_t r);
    in_bus.command       <= r.cmd;
    in_bus.entry_index   <= r.idx;
    in_bus.entry_kind    <= r.entry.kind;
    in_bus.entry_hours   <= r.entry.hours;
    in_bus.entry_minutes <= r.entry.minutes;
    in_bus.epoch_seconds <= r.epoch;
    in_bus.valid         <= 1'b1;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (r.cmd == CMD_WRITE) begin
      if (r.idx < ENTRIES) slot_model[r.idx] = r.entry;
      n_writes++;
    end else begin
      alarm_q.push_back(r.known ? r.want : next_alarm(r.epoch));
      n_queries++;
    end
  endtask

  task automatic idle_sender();
    int g;
    g = quiet ? 0 : gap_len();
    if (g > 0) begin
      in_bus.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // multiplier changes only with the block idle
  task automatic set_multiplier(logic [MULT_W-1:0] m);
    in_bus.valid <= 1'b0;
    while (alarm_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_bus.period_multiplier <= m;
    cfg_bus.valid             <= 1'b1;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    mult_model = m;
    n_cfg++;
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        n_holds++;
        out_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_left = gap_len();
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    alarm_t got;
    alarm_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.minute = out_bus.next_minute;
      got.found  = out_bus.alarm_found;
      n_results++;
      if (alarm_q.size() == 0) begin
        note_error($sformatf("result with no query waiting: next_minute %0d alarm_found %0b",
                             got.minute, got.found));
      end else begin
        want = alarm_q.pop_front();
        if (got.minute !== want.minute || got.found !== want.found)
          note_error($sformatf({"result %0d: next_minute exp %0d got %0d, ",
                                "alarm_found exp %0b got %0b"},
                               n_results, want.minute, got.minute, want.found, got.found));
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TIMEOUT: no transaction for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, alarm_q.size());
    $display("periodic_alarm_next_minute verification failed");
    $finish;
  end

  initial begin : stimulus
    stim_row_t         r;
    int                pick;
    logic [MULT_W-1:0] m;
    logic [EPOCH_W-1:0] e;

    rst_n                     <= 1'b0;
    in_bus.valid              <= 1'b0;
    in_bus.command            <= CMD_WRITE;
    in_bus.entry_index        <= '0;
    in_bus.entry_kind         <= KIND_OFF;
    in_bus.entry_hours        <= '0;
    in_bus.entry_minutes      <= '0;
    in_bus.epoch_seconds      <= '0;
    cfg_bus.valid             <= 1'b0;
    cfg_bus.period_multiplier <= '0;
    for (int i = 0; i < ENTRIES; i++) slot_model[i] = '0;
    mult_model = MULT_RESET;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, zero periods, disabled kinds, hour edges
    add_query(32'd0, 1'b1, NONE_MINUTE, 1'b0);
    add_write(0, KIND_MINUTES, 0, 1);
    add_query(32'd0, 1'b1, 27'd1, 1'b1);
    add_query(EPOCH_MAX, 1'b1, NONE_MINUTE, 1'b0);
    add_write(1, KIND_HOURS, 255, 63);
    add_query(32'd0);
    add_write(0, KIND_OFF, 200, 33);
    add_query(32'd0);
    add_write(2, KIND_HOURS, 0, 10);
    add_write(3, KIND_SPARE, 5, 5);
    add_write(4, KIND_MINUTES, 9, 0);
    add_write(6, KIND_HOURS, 1, 0);
    add_query(32'd3598);     // now on the hour: offset not in the future
    add_query(32'd3597);
    add_write(7, KIND_HOURS, 1, 63);
    add_query(EPOCH_MAX);
    add_write(5, KIND_MINUTES, 255, 63);
    add_query(32'd1000000000);
    add_cfg(8'd0);
    add_query(32'd123456789, 1'b1, NONE_MINUTE, 1'b0);
    add_cfg(8'd255);
    add_query(EPOCH_MAX);
    add_query(32'd2147483648);
    add_query(32'hFFFF_FFF0);

    foreach (plan[i]) begin
      if (plan[i].op == ROW_CFG) begin
        set_multiplier(plan[i].mult);
      end else begin
        send_item(plan[i]);
        idle_sender();
      end
    end

    // random phases, one multiplier each
    for (int phase = 0; phase < PHASES; phase++) begin
      unique case (phase)
        0:       m = 8'd255;
        1:       m = 8'd0;
        2:       m = 8'd2;
        3:       m = 8'd1;
        4:       m = MULT_W'($urandom_range(3, 254));
        5:       m = MULT_W'($urandom_range(2, 5));
        6:       m = 8'd255;
        default: m = MULT_W'($urandom_range(1, 255));
      endcase
      set_multiplier(m);
      quiet = (phase == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r.op    = ROW_ITEM;
        r.mult  = '0;
        r.known = 1'b0;
        r.want  = '0;
        if ($urandom_range(0, 9) < 4) begin
          r.cmd = CMD_WRITE;
          r.idx = IDX_W'($urandom_range(0, MAX_SLOTS - 1));
          pick  = $urandom_range(0, 9);
          r.entry.kind = (pick < 4) ? KIND_MINUTES : (pick < 8) ? KIND_HOURS :
                         (pick == 8) ? KIND_OFF : KIND_SPARE;
          pick = $urandom_range(0, 9);
          r.entry.hours   = (pick < 7) ? HOURS_W'($urandom_range(1, 6)) :
                            (pick < 9) ? HOURS_W'($urandom_range(0, 255)) : '0;
          r.entry.minutes = MINS_W'($urandom_range(0, 63));
          r.epoch         = $urandom;
        end else begin
          r.cmd   = CMD_QUERY;
          r.idx   = IDX_W'($urandom_range(0, MAX_SLOTS - 1));
          r.entry = pan_entry_t'(16'($urandom_range(0, 65535)));
          pick    = $urandom_range(0, 9);
          if (pick == 0) begin
            e = EPOCH_MAX - $urandom_range(0, 200);
          end else if (pick < 3) begin
            // around an hour boundary
            e = $urandom_range(1, 1193045) * 3600 + $urandom_range(0, 3660) - 2;
          end else if (pick == 3) begin
            e = $urandom_range(0, 10000);
          end else begin
            e = $urandom;
            if (e > EPOCH_MAX) e = EPOCH_MAX;
          end
          r.epoch = e;
        end
        if (phase == 3 && k == 5) hold_req = 1'b1;
        send_item(r);
        if (phase == 4 && k == 30) begin
          in_bus.valid <= 1'b0;
          while (alarm_q.size() != 0) @(posedge clk);
        end else begin
          idle_sender();
        end
      end
    end
    quiet = 1'b0;

    in_bus.valid <= 1'b0;
    while (alarm_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d slot writes and %0d queries sent, %0d results checked",
             n_writes, n_queries, n_results);
    $display("Summary: %0d multiplier settings, %0d long output hold-offs, %0d mismatches",
             n_cfg, n_holds, mismatches);
    if (mismatches == 0) begin
      $display("periodic_alarm_next_minute verification clean");
    end else begin
      $display("periodic_alarm_next_minute verification failed");
    end
    $finish;
  end

endmodule
